### hdl/ppu_pkg.sv
// Shared types, constants and helper functions for the palette pixel unpacker.
`default_nettype none
package ppu_pkg;

  localparam int unsigned PALETTE_ENTRIES = 16;
  localparam int unsigned SLOT_W          = $clog2(PALETTE_ENTRIES);
  localparam int unsigned COLOUR_W        = 13;
  localparam int unsigned MAX_WIDTH       = 4096;
  localparam int unsigned MAX_HEIGHT      = 1024;
  localparam int unsigned COL_W           = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W          = $clog2(MAX_HEIGHT);
  localparam int unsigned WIDTH_W         = COL_W + 1;
  localparam int unsigned HEIGHT_W        = LINE_W + 1;
  localparam int unsigned CFG_DATA_W      = 13;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);

  typedef enum logic {
    ACT_DATA    = 1'b0,
    ACT_PALETTE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_2BPP = 2'd1,
    DEPTH_4BPP = 2'd2,
    DEPTH_8BPP = 2'd3
  } depth_e;

  typedef enum logic [1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_DEPTH_MODE   = 2'd2
  } cfg_index_e;

  typedef struct packed {
    action_e               action;
    logic [7:0]            data_byte;
    logic [SLOT_W-1:0]     palette_slot;
    logic [COLOUR_W-1:0]   palette_colour;
  } cmd_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  line_width;
    logic [HEIGHT_W-1:0] frame_height;
    depth_e              depth_mode;
  } cfg_t;

  // Each 4-bit channel is widened by repeating the nibble; bit 12 makes the pixel clear.
  function automatic logic [31:0] colour_to_argb(input logic [COLOUR_W-1:0] c);
    logic [7:0] a;
    a = c[12] ? 8'h00 : 8'hFF;
    return {a, c[3:0], c[3:0], c[7:4], c[7:4], c[11:8], c[11:8]};
  endfunction

endpackage
`default_nettype wire

### hdl/ppu_front.sv
// Front end: accepts input items, tags them as data or palette writes and queues them.
`default_nettype none
module ppu_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic [ppu_pkg::SLOT_W-1:0]    palette_slot_i,
  input  wire logic [ppu_pkg::COLOUR_W-1:0]  palette_colour_i,
  output logic                               head_valid_o,
  output ppu_pkg::cmd_t                      head_o,
  input  wire logic                          pop_i
);

  ppu_pkg::cmd_t                  mem_q [ppu_pkg::QUEUE_DEPTH];
  ppu_pkg::cmd_t                  cmd;
  logic [ppu_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ppu_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ppu_pkg::QPTR_W:0]       count_q, count_d;
  logic                           push;
  logic                           pop;

  always_comb begin
    cmd.action         = action_i ? ppu_pkg::ACT_PALETTE : ppu_pkg::ACT_DATA;
    cmd.data_byte      = data_byte_i;
    cmd.palette_slot   = palette_slot_i;
    cmd.palette_colour = palette_colour_i;
  end

  assign in_ready_o   = (count_q != (ppu_pkg::QPTR_W + 1)'(ppu_pkg::QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !pop_i || !head_valid_o)
    else $error("queue popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (ppu_pkg::QPTR_W + 1)'(ppu_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

### hdl/ppu_back.sv
// Back end: palette store, column and line counters, and pixel generation one per cycle unless the output stalls.
`default_nettype none
module ppu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ppu_pkg::cfg_t  cfg_i,
  input  wire logic           head_valid_i,
  input  wire ppu_pkg::cmd_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         argb_o,
  output logic                last_of_byte_o,
  output logic                end_of_line_o,
  output logic                end_of_frame_o
);

  logic [ppu_pkg::COLOUR_W-1:0] palette_q [ppu_pkg::PALETTE_ENTRIES];
  logic [ppu_pkg::COL_W-1:0]    col_q, col_d;
  logic [ppu_pkg::LINE_W-1:0]   line_q, line_d;
  logic [2:0]                   pix_q, pix_d;
  logic                         out_valid_q;
  logic [31:0]                  argb_q;
  logic                         last_q, eol_q, eof_q;

  logic [ppu_pkg::WIDTH_W-1:0]  width;
  logic [ppu_pkg::HEIGHT_W-1:0] height;
  logic [ppu_pkg::WIDTH_W-1:0]  col_plus;
  logic [ppu_pkg::HEIGHT_W-1:0] line_plus;
  logic [5:0]                   shamt_wide;
  logic [2:0]                   shamt;
  logic [7:0]                   field;
  logic [3:0]                   idx_mask;
  logic [3:0]                   idx;
  logic [ppu_pkg::COLOUR_W-1:0] colour;
  logic                         is_palette;
  logic                         is_data;
  logic                         emit;
  logic                         eol;
  logic                         eof;
  logic                         last;

  // Zero sizes count as one, oversized ones saturate to the maximum.
  always_comb begin
    if (cfg_i.line_width == '0) begin
      width = ppu_pkg::WIDTH_W'(1);
    end else if (cfg_i.line_width > ppu_pkg::WIDTH_W'(ppu_pkg::MAX_WIDTH)) begin
      width = ppu_pkg::WIDTH_W'(ppu_pkg::MAX_WIDTH);
    end else begin
      width = cfg_i.line_width;
    end
    if (cfg_i.frame_height == '0) begin
      height = ppu_pkg::HEIGHT_W'(1);
    end else if (cfg_i.frame_height > ppu_pkg::HEIGHT_W'(ppu_pkg::MAX_HEIGHT)) begin
      height = ppu_pkg::HEIGHT_W'(ppu_pkg::MAX_HEIGHT);
    end else begin
      height = cfg_i.frame_height;
    end
  end

  assign is_palette = head_valid_i && (head_i.action == ppu_pkg::ACT_PALETTE);
  assign is_data    = head_valid_i && (head_i.action == ppu_pkg::ACT_DATA);
  assign emit       = is_data && (!out_valid_q || out_ready_i);

  assign col_plus  = {1'b0, col_q} + ppu_pkg::WIDTH_W'(1);
  assign line_plus = {1'b0, line_q} + ppu_pkg::HEIGHT_W'(1);
  assign eol       = (col_plus >= width);
  assign eof       = eol && (line_plus >= height);

  // A byte ends at its last field or earlier when the line ends inside it.
  assign last = eol || (pix_q == (3'd7 >> cfg_i.depth_mode));

  assign shamt_wide = 6'(pix_q) << cfg_i.depth_mode;
  assign shamt      = shamt_wide[2:0];
  assign field      = head_i.data_byte >> shamt;

  always_comb begin
    unique case (cfg_i.depth_mode)
      ppu_pkg::DEPTH_1BPP: idx_mask = 4'h1;
      ppu_pkg::DEPTH_2BPP: idx_mask = 4'h3;
      ppu_pkg::DEPTH_4BPP: idx_mask = 4'hF;
      ppu_pkg::DEPTH_8BPP: idx_mask = 4'hF;
      default:             idx_mask = 4'hF;
    endcase
  end

  assign idx = field[3:0] & idx_mask;

  always_comb begin
    colour = palette_q[idx];
    if (cfg_i.depth_mode == ppu_pkg::DEPTH_8BPP) begin
      colour[7:4] = head_i.data_byte[7:4];
    end
  end

  assign pop_o = is_palette || (emit && last);

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    pix_d  = pix_q;
    if (emit) begin
      pix_d = last ? 3'd0 : pix_q + 3'd1;
      if (eol) begin
        col_d  = '0;
        line_d = eof ? '0 : line_plus[ppu_pkg::LINE_W-1:0];
      end else begin
        col_d = col_plus[ppu_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppu_pkg::PALETTE_ENTRIES; i++) begin
        palette_q[i] <= '0;
      end
      col_q       <= '0;
      line_q      <= '0;
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (is_palette) begin
        palette_q[head_i.palette_slot] <= head_i.palette_colour;
      end
      col_q  <= col_d;
      line_q <= line_d;
      pix_q  <= pix_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      argb_q <= ppu_pkg::colour_to_argb(colour);
      last_q <= last;
      eol_q  <= eol;
      eof_q  <= eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign argb_o         = argb_q;
  assign last_of_byte_o = last_q;
  assign end_of_line_o  = eol_q;
  assign end_of_frame_o = eof_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && eof_q) |-> (eol_q && last_q))
    else $error("frame end without line end and byte end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && eol_q) |-> last_q)
    else $error("line end did not close the byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && eol) |=> (col_q == '0))
    else $error("column counter not cleared at line end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (pix_q == '0))
    else $error("pixel counter left mid-byte with no item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_data && pop_o) |-> emit)
    else $error("data item dropped without output");

endmodule
`default_nettype wire

### hdl/palette_pixel_unpacker.sv
// Top level: configuration registers, front queue and pixel back end.
//
//  Channel  Handshake                 Payload
//  in       in_valid_i / in_ready_o   action_i, data_byte_i, palette_slot_i, palette_colour_i
//  out      out_valid_o / out_ready_i argb_o, last_of_byte_o, end_of_line_o, end_of_frame_o
//  cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A data item yields one pixel per cycle while the output is not stalled: 8, 4, 2 or 1
// pixels for 1, 2, 4 or 8 bpp, fewer where the line ends inside the byte; a palette
// write yields no pixel. The single pixel generator in the back end sets that rate.
// Items pass a four-entry queue, so up to four items are still taken while the output
// stalls; after that in_ready_o drops until the back end pops one.
// Reset clears the palette, the counters and the queue and loads the default sizes.
`default_nettype none
module palette_pixel_unpacker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            action_i,
  input  wire logic [7:0]                      data_byte_i,
  input  wire logic [ppu_pkg::SLOT_W-1:0]      palette_slot_i,
  input  wire logic [ppu_pkg::COLOUR_W-1:0]    palette_colour_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [31:0]                          argb_o,
  output logic                                 last_of_byte_o,
  output logic                                 end_of_line_o,
  output logic                                 end_of_frame_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [ppu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ppu_pkg::cfg_t  cfg_q;
  ppu_pkg::cmd_t  head;
  logic           head_valid;
  logic           pop;
  logic           cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width   <= ppu_pkg::WIDTH_RESET;
      cfg_q.frame_height <= ppu_pkg::HEIGHT_RESET;
      cfg_q.depth_mode   <= ppu_pkg::DEPTH_8BPP;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        ppu_pkg::CFG_LINE_WIDTH: begin
          cfg_q.line_width <= cfg_data_i[ppu_pkg::WIDTH_W-1:0];
        end
        ppu_pkg::CFG_FRAME_HEIGHT: begin
          cfg_q.frame_height <= cfg_data_i[ppu_pkg::HEIGHT_W-1:0];
        end
        ppu_pkg::CFG_DEPTH_MODE: begin
          cfg_q.depth_mode <= ppu_pkg::depth_e'(cfg_data_i[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  ppu_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .palette_slot_i   (palette_slot_i),
    .palette_colour_i (palette_colour_i),
    .head_valid_o     (head_valid),
    .head_o           (head),
    .pop_i            (pop)
  );

  ppu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .argb_o         (argb_o),
    .last_of_byte_o (last_of_byte_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule
`default_nettype wire
